FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the matcher RTL.
// Included by threshold_point_matcher_unit; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TPM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define TPM_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

FILE: rtl/core/tpm_pkg.sv
// Shared types and constants for the threshold point matcher.
// No dependencies; imported by tpm_dist and the top level.
package tpm_pkg;

    localparam int LIMIT_W = 35;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_INNER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER = 1'b1;

    localparam logic [LIMIT_W-1:0] INNER_RESET = 35'd2621;
    localparam logic [LIMIT_W-1:0] OUTER_RESET = 35'd16384;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_INS,
        ST_SCAN,
        ST_LOAD,
        ST_MARK
    } t_state;

    // Verdict of the distance unit for one stored point
    typedef struct packed {
        logic valid;
        logic match;    // dist^2 <= inner limit
        logic near;     // dist^2 <  outer limit
    } t_dist_res;

endpackage

FILE: rtl/core/tpm_dist.sv
// Pipelined squared-distance and threshold compare unit.
// Depends on tpm_pkg for LIMIT_W and t_dist_res.
module tpm_dist
    import tpm_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int SLOT_W = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic [SLOT_W-1:0]            i_slot,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_sx,
    input  logic signed [COORD_BITS-1:0] i_sy,
    input  logic [LIMIT_W-1:0]           i_inner,
    input  logic [LIMIT_W-1:0]           i_outer,
    output t_dist_res                    o_res,
    output logic [SLOT_W-1:0]            o_slot
);

    localparam int DW = COORD_BITS + 1;
    localparam int SQ_W = 2 * DW;
    localparam int CMP_W = (SQ_W > LIMIT_W) ? SQ_W : LIMIT_W;

    logic signed [DW-1:0] dx, dy;
    logic [DW-1:0]        r_ax, r_ay;
    logic [SQ_W-1:0]      r_sqx, r_sqy;
    logic [SQ_W-1:0]      sum;
    logic [2:0]           r_vld;
    logic [SLOT_W-1:0]    r_slot1, r_slot2, r_slot3;
    logic                 r_match, r_near;

    assign dx = DW'(i_px) - DW'(i_sx);
    assign dy = DW'(i_py) - DW'(i_sy);
    assign sum = r_sqx + r_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: magnitudes of the differences
        r_ax    <= dx[DW-1] ? DW'(-dx) : DW'(dx);
        r_ay    <= dy[DW-1] ? DW'(-dy) : DW'(dy);
        r_slot1 <= i_slot;
        // stage 2: squares
        r_sqx   <= SQ_W'(r_ax) * SQ_W'(r_ax);
        r_sqy   <= SQ_W'(r_ay) * SQ_W'(r_ay);
        r_slot2 <= r_slot1;
        // stage 3: sum and compare
        r_match <= CMP_W'(sum) <= CMP_W'(i_inner);
        r_near  <= CMP_W'(sum) <  CMP_W'(i_outer);
        r_slot3 <= r_slot2;
    end

    assign o_res.valid = r_vld[2];
    assign o_res.match = r_match;
    assign o_res.near  = r_near;
    assign o_slot      = r_slot3;

endmodule

FILE: rtl/core/threshold_point_matcher_unit.sv
// Threshold point matcher: table of 2-D points with gated distance matching.
// Depends on tpm_pkg, tpm_dist and assert_macros.svh.
//
// Usage:
//   s_axis carries one point per request: tdata = {y, x}, tlast = frame end.
//   m_axis carries results: tdata = {count, slot, my, mx, dy, dx},
//   tuser = {frame_done, is_match}, tlast = last result of the input point.
//   Write limits on i_cfg_* (0 inner, 1 outer) only while idle; not enforced.
// Sequence per point with N stored points:
//   a compare pass (one read per cycle into the 3-stage distance unit),
//   an insert step, a scan of the N slots that loads one result per match,
//   a marker result when the point ends a frame, and a return to idle.
//   Results come in slot order from the lowest matched slot; the marker
//   comes last. s_axis_tready is high only between points.
// Reset clears the table count and restores the default limits; the table
//   contents are not cleared. A stalled receiver holds the result register
//   and the scan waits on it; nothing is dropped.
module threshold_point_matcher_unit
    import tpm_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int COORD_BITS = 16,
    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W = $clog2(CAPACITY + 1),
    localparam int IN_W = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int RAW_W = 4 * COORD_BITS + SLOT_W + CNT_W,
    localparam int OUT_W = ((RAW_W + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    // point input
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,  // point_x, point_y
    input  logic                 s_axis_tlast,  // frame_end
    // result output
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // detected_x, detected_y, matched_x, matched_y, matched_slot, stored_count
    output logic [OUT_W-1:0]     m_axis_tdata,
    output logic [1:0]           m_axis_tuser,  // is_match, frame_done
    output logic                 m_axis_tlast   // last_result
);

    t_state r_state, n_state;

    logic signed [COORD_BITS-1:0] r_px, n_px, r_py, n_py;
    logic                         r_fe, n_fe;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [CNT_W-1:0]             r_limit, n_limit;
    logic [CNT_W-1:0]             r_idx, n_idx;
    logic [CNT_W-1:0]             r_rcv, n_rcv;
    logic                         r_novel, n_novel;
    logic [CAPACITY-1:0]          r_flags, n_flags;
    logic [LIMIT_W-1:0]           r_inner, r_outer;

    logic                         r_out_vld;
    logic [OUT_W-1:0]             r_out_data, n_out_data;
    logic [1:0]                   r_out_user, n_out_user;
    logic                         r_out_last, n_out_last;
    logic                         out_load, out_free;

    logic signed [COORD_BITS-1:0] r_mem_x [CAPACITY];
    logic signed [COORD_BITS-1:0] r_mem_y [CAPACITY];
    logic signed [COORD_BITS-1:0] r_rd_x, r_rd_y;
    logic [SLOT_W-1:0]            r_rd_slot;
    logic                         r_rd_vld;
    logic                         rd_en, wr_en;
    logic [SLOT_W-1:0]            rd_addr;

    t_dist_res                    dres;
    logic [SLOT_W-1:0]            dslot;
    logic [CAPACITY-1:0]          idx_bit;

    tpm_dist #(
        .COORD_BITS(COORD_BITS),
        .SLOT_W    (SLOT_W)
    ) u_dist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_rd_vld),
        .i_slot (r_rd_slot),
        .i_px   (r_px),
        .i_py   (r_py),
        .i_sx   (r_rd_x),
        .i_sy   (r_rd_y),
        .i_inner(r_inner),
        .i_outer(r_outer),
        .o_res  (dres),
        .o_slot (dslot)
    );

    assign rd_addr  = r_idx[SLOT_W-1:0];
    assign idx_bit  = CAPACITY'(1) << rd_addr;
    assign out_free = !r_out_vld || m_axis_tready;

    always_comb begin
        n_state    = r_state;
        n_px       = r_px;
        n_py       = r_py;
        n_fe       = r_fe;
        n_count    = r_count;
        n_limit    = r_limit;
        n_idx      = r_idx;
        n_rcv      = r_rcv;
        n_novel    = r_novel;
        n_flags    = r_flags;
        n_out_data = '0;
        n_out_user = '0;
        n_out_last = 1'b0;
        out_load   = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        s_axis_tready = (r_state == ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_px    = s_axis_tdata[COORD_BITS-1:0];
                    n_py    = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
                    n_fe    = s_axis_tlast;
                    n_limit = r_count;
                    n_idx   = '0;
                    n_rcv   = '0;
                    n_novel = 1'b1;
                    n_flags = '0;
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (r_idx < r_limit) begin
                    rd_en = 1'b1;
                    n_idx = r_idx + CNT_W'(1);
                end
                if (dres.valid) begin
                    n_rcv = r_rcv + CNT_W'(1);
                    if (dres.match) begin
                        n_flags = r_flags | (CAPACITY'(1) << dslot);
                    end
                    if (dres.near) begin
                        n_novel = 1'b0;
                    end
                end
                if (r_rcv == r_limit) begin
                    n_state = ST_INS;
                end
            end
            ST_INS: begin
                if (r_novel && (r_count < CNT_W'(CAPACITY))) begin
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
                n_idx   = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_idx == r_limit) begin
                    n_state = r_fe ? ST_MARK : ST_IDLE;
                end else if (r_flags[rd_addr]) begin
                    rd_en   = 1'b1;
                    n_state = ST_LOAD;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_out_data[RAW_W-1:0] = {r_count, rd_addr, r_rd_y, r_rd_x, r_py, r_px};
                    n_out_user = 2'b01;
                    n_out_last = !r_fe && ((r_flags & ~idx_bit) == '0);
                    n_flags    = r_flags & ~idx_bit;
                    n_idx      = r_idx + CNT_W'(1);
                    n_state    = ST_SCAN;
                end
            end
            ST_MARK: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_out_data[RAW_W-1:RAW_W-CNT_W] = r_count;
                    n_out_user = 2'b10;
                    n_out_last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_inner   <= INNER_RESET;
            r_outer   <= OUTER_RESET;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= rd_en && (r_state == ST_CMP);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INNER: r_inner <= i_cfg_data;
                    CFG_OUTER: r_outer <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_px    <= n_px;
        r_py    <= n_py;
        r_fe    <= n_fe;
        r_limit <= n_limit;
        r_idx   <= n_idx;
        r_rcv   <= n_rcv;
        r_novel <= n_novel;
        r_flags <= n_flags;
        if (out_load) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
            r_out_last <= n_out_last;
        end
    end

    // point table: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_x[r_count[SLOT_W-1:0]] <= r_px;
            r_mem_y[r_count[SLOT_W-1:0]] <= r_py;
        end
        if (rd_en) begin
            r_rd_x    <= r_mem_x[rd_addr];
            r_rd_y    <= r_mem_y[rd_addr];
            r_rd_slot <= rd_addr;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

`include "assert_macros.svh"

    `TPM_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY),
        "table count above capacity")
    `TPM_ASSERT(a_rcv_bound, i_clk, i_rst_n, (r_state != ST_CMP) || (r_rcv <= r_limit),
        "more verdicts than reads")
    `TPM_ASSERT(a_accept_busy, i_clk, i_rst_n,
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_CMP),
        "accept did not start a compare pass")
    `TPM_NEVER(a_slot_range, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[0] &&
        (CNT_W'(m_axis_tdata[RAW_W-CNT_W-1:RAW_W-CNT_W-SLOT_W]) >=
         m_axis_tdata[RAW_W-1:RAW_W-CNT_W]),
        "matched slot beyond stored count")

endmodule
